### design/sha256_pkg.sv
package sha256_pkg;

    typedef logic [31:0] word_t;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

endpackage

### design/sha256_stream_hasher.sv
// SHA-256 stream hasher.
// Input channel (in_valid/in_ready): one request carries data_byte, byte_valid
// and end_of_message. A request with byte_valid appends data_byte; a request
// with end_of_message closes the message (after its byte, if any).
// Output channel (out_valid/out_ready): eight digest words, word 0 first,
// last_word high on word 7. Afterwards the hasher restarts for a new message.
// Sequence: a byte that does not fill the block leaves in_ready high. A byte that
// fills the block starts the compression: load the 16 message words, then 64
// rounds of one shared round unit, then add into the chaining words; in_ready is
// low throughout. End of message feeds the padding one byte per cycle through
// the same buffer, compresses once or twice, then presents the digest words one
// per cycle as the receiver takes them. A stalled receiver simply holds the
// current word; in_ready stays low until the eighth word is taken.
// Reset loads the initial hash values and clears the byte counters; the block
// buffer itself needs no reset.
module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        last_word
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_OUT} state_t;

    state_t      state_reg;
    logic        fin_reg;       // final padding block: length bytes go in from LEN_POS
    logic [3:0]  len_idx_reg;   // 0: no padding, 1: pad byte pending, 2: padding
    logic [5:0]  fill_reg;
    logic [60:0] total_reg;
    logic [6:0]  rnd_reg;
    logic [2:0]  wnum_reg;
    word_t       h_reg [8];
    word_t       s_reg [8];
    word_t       w_reg [16];
    logic [7:0]  bank0_mem [16];
    logic [7:0]  bank1_mem [16];
    logic [7:0]  bank2_mem [16];
    logic [7:0]  bank3_mem [16];
    logic [31:0] rd_word_reg;

    // current byte pushed into buffer while padding
    logic [7:0]  pad_b;
    logic [63:0] bits;
    logic        push;
    logic [7:0]  push_b;

    // round unit
    word_t e, a, t1, t2, wi, w15, w2, sig0, sig1, wnew;

    assign bits = {total_reg, 3'b000};

    always_comb
    begin
        pad_b = 8'h00;
        if (len_idx_reg == 4'd1)
            pad_b = PAD_BYTE;
        if (fin_reg && fill_reg >= LEN_POS)
            pad_b = bits[6'(63 - 8 * (fill_reg - LEN_POS)) -: 8];
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        push   = 1'b0;
        push_b = data_byte;
        if (state_reg == ST_IDLE && in_valid && byte_valid)
            push = 1'b1;
        else if (state_reg == ST_PAD)
        begin
            push   = 1'b1;
            push_b = pad_b;
        end
    end

    // schedule: w_reg holds a 16-word window, w_reg[0] is w[i]
    always_comb
    begin
        w15  = w_reg[1];
        w2   = w_reg[14];
        sig0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        sig1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        wnew = w_reg[0] + sig0 + w_reg[9] + sig1;
        wi   = w_reg[0];
        e    = s_reg[4];
        a    = s_reg[0];
        t1 = s_reg[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
           + ((e & s_reg[5]) ^ (~e & s_reg[6])) + ROUND_K[rnd_reg[5:0]] + wi;
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
           + ((a & s_reg[1]) ^ (a & s_reg[2]) ^ (s_reg[1] & s_reg[2]));
    end

    // buffer write and word read (load window word by word);
    // split by byte lane so a word comes from one address
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            case (fill_reg[1:0])
                2'd0:    bank0_mem[fill_reg[5:2]] <= push_b;
                2'd1:    bank1_mem[fill_reg[5:2]] <= push_b;
                2'd2:    bank2_mem[fill_reg[5:2]] <= push_b;
                default: bank3_mem[fill_reg[5:2]] <= push_b;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_word_reg <= {bank0_mem[rnd_reg[3:0]], bank1_mem[rnd_reg[3:0]],
                        bank2_mem[rnd_reg[3:0]], bank3_mem[rnd_reg[3:0]]};
    end

    // sequencer: rnd 0..15 read words, 16 load last, then 64 rounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fin_reg     <= 1'b0;
            len_idx_reg <= 4'd0;
            fill_reg    <= 6'd0;
            total_reg   <= 61'd0;
            rnd_reg     <= 7'd0;
            wnum_reg    <= 3'd0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= INIT_H[i];
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (byte_valid)
                        begin
                            total_reg <= total_reg + 61'd1;
                            fill_reg  <= fill_reg + 6'd1;
                        end
                        fin_reg     <= 1'b0;
                        rnd_reg     <= 7'd0;
                        if (byte_valid && fill_reg == 6'd63)
                            state_reg <= ST_ROUND;
                        else if (end_of_message)
                            state_reg <= ST_PAD;
                        // flag the pad byte as pending on end of message
                        len_idx_reg <= end_of_message ? 4'd1 : 4'd0;
                    end
                end
                ST_PAD:
                begin
                    // len_idx 1: 0x80 pending; 2: zeros/length
                    fill_reg <= fill_reg + 6'd1;
                    if (len_idx_reg == 4'd1)
                        len_idx_reg <= 4'd2;
                    if (fill_reg == 6'd55)
                        fin_reg <= 1'b1;
                    rnd_reg <= 7'd0;
                    if (fill_reg == 6'd63)
                        state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    if (rnd_reg == 7'd16)
                        rnd_reg <= 7'd64;
                    else
                        rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg <= 7'd16)
                    begin
                        if (rnd_reg != 7'd0)
                        begin
                            for (int i = 0; i < 15; i++)
                                w_reg[i] <= w_reg[i + 1];
                            w_reg[15] <= rd_word_reg;
                        end
                        for (int i = 0; i < 8; i++)
                            s_reg[i] <= h_reg[i];
                    end
                    else
                    begin
                        s_reg[7] <= s_reg[6];
                        s_reg[6] <= s_reg[5];
                        s_reg[5] <= s_reg[4];
                        s_reg[4] <= s_reg[3] + t1;
                        s_reg[3] <= s_reg[2];
                        s_reg[2] <= s_reg[1];
                        s_reg[1] <= s_reg[0];
                        s_reg[0] <= t1 + t2;
                        for (int i = 0; i < 15; i++)
                            w_reg[i] <= w_reg[i + 1];
                        w_reg[15] <= wnew;
                        if (rnd_reg == 7'd127)
                            state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + s_reg[i];
                    wnum_reg <= 3'd0;
                    if (len_idx_reg == 4'd0)
                        state_reg <= ST_IDLE;
                    else if (fin_reg)
                        state_reg <= ST_OUT;
                    else
                        state_reg <= ST_PAD;
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        wnum_reg <= wnum_reg + 3'd1;
                        if (wnum_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= INIT_H[i];
                            fill_reg    <= 6'd0;
                            total_reg   <= 61'd0;
                            fin_reg     <= 1'b0;
                            len_idx_reg <= 4'd0;
                            state_reg   <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = h_reg[wnum_reg];
    assign word_number = wnum_reg;
    assign last_word   = (wnum_reg == 3'd7);

endmodule

### tb/sha256_stream_hasher_test.sv
`timescale 1ns / 100ps

module sha256_stream_hasher_test;
    import sha256_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       eom;
        logic       use_known;
        word_t      known_w0;
    } stim_row_t;

    typedef struct {
        word_t      word;
        logic [2:0] num;
        logic       last;
    } digest_entry_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        end_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    sha256_stream_hasher dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .byte_valid(byte_valid),
        .end_of_message(end_of_message),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .digest_word(digest_word),
        .word_number(word_number),
        .last_word(last_word)
    );

    // Predictor state
    word_t         hash_state [8];
    logic [7:0]    msg_block [64];
    int unsigned   block_fill;
    logic [60:0]   msg_len;
    digest_entry_t digest_queue [$];
    word_t         known_first_word [$];

    int error_count;
    int requests_sent;
    int messages_sent;
    int words_seen;
    int idle_cycles;
    bit stim_done;

    function automatic word_t rotr(word_t v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic hash_block();
        word_t sched [64];
        word_t a [8];
        word_t t1;
        word_t t2;
        for (int i = 0; i < 16; i++)
        begin
            sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2],
                        msg_block[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            sched[i] = sched[i-16] + sched[i-7]
                + (rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3))
                + (rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10));
        end
        a = hash_state;
        for (int i = 0; i < 64; i++)
        begin
            t1 = a[7] + (rotr(a[4], 6) ^ rotr(a[4], 11) ^ rotr(a[4], 25))
                + ((a[4] & a[5]) ^ (~a[4] & a[6])) + ROUND_K[i] + sched[i];
            t2 = (rotr(a[0], 2) ^ rotr(a[0], 13) ^ rotr(a[0], 22))
                + ((a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]));
            a[7] = a[6]; a[6] = a[5]; a[5] = a[4]; a[4] = a[3] + t1;
            a[3] = a[2]; a[2] = a[1]; a[1] = a[0]; a[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += a[i];
    endtask

    task automatic absorb_byte(logic [7:0] b);
        msg_block[block_fill] = b;
        block_fill++;
        if (block_fill == 64)
        begin
            hash_block();
            block_fill = 0;
        end
    endtask

    task automatic restart_hash();
        hash_state = INIT_H;
        block_fill = 0;
        msg_len = '0;
    endtask

    // Update the predictor with one accepted request
    task automatic predict_request(logic [7:0] b, logic has_byte, logic eom);
        logic [63:0] bit_len;
        digest_entry_t e;
        if (has_byte)
        begin
            msg_len = msg_len + 1;
            absorb_byte(b);
        end
        if (eom)
        begin
            bit_len = {msg_len, 3'b000};
            absorb_byte(PAD_BYTE);
            while (block_fill != LEN_POS)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(bit_len[63-8*i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                e.word = hash_state[i];
                e.num = 3'(i);
                e.last = (i == 7);
                digest_queue = {digest_queue, e};
            end
            restart_hash();
            messages_sent++;
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_request(stim_row_t row);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= row.data;
        byte_valid <= row.has_byte;
        end_of_message <= row.eom;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(row.data, row.has_byte, row.eom);
        if (row.use_known && row.eom)
            known_first_word = {known_first_word, row.known_w0};
        requests_sent++;
    endtask

    function automatic stim_row_t mk(logic [7:0] d, logic v, logic e);
        stim_row_t r;
        r.data = d; r.has_byte = v; r.eom = e; r.use_known = 0; r.known_w0 = '0;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Check each accepted digest word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            words_seen++;
            if (digest_queue.size() == 0)
            begin
                $display("%0t: unexpected word %h num %0d", $time, digest_word, word_number);
                error_count++;
            end
            else
            begin
                digest_entry_t e;
                e = digest_queue.pop_front();
                if (e.word !== digest_word || e.num !== word_number || e.last !== last_word)
                begin
                    $display("%0t: expected %h/%0d/%0b, actual %h/%0d/%0b", $time,
                             e.word, e.num, e.last, digest_word, word_number, last_word);
                    error_count++;
                end
                if (e.num == 0 && known_first_word.size() > 0 && e.last == 0)
                begin
                    word_t k;
                    k = known_first_word[0];
                    if (k !== 32'h0)
                    begin
                        known_first_word.pop_front();
                        if (k !== digest_word)
                        begin
                            $display("%0t: expected known %h, actual %h", $time, k,
                                     digest_word);
                            error_count++;
                        end
                    end
                end
            end
        end
    end

    // Receiver stalls
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int g;
            g = gap_len();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sha256_stream_hasher_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        stim_row_t plan [$];
        stim_row_t row;
        int n;
        int mode;
        in_valid = 1'b0;
        data_byte = '0;
        byte_valid = 1'b0;
        end_of_message = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        requests_sent = 0;
        messages_sent = 0;
        words_seen = 0;
        idle_cycles = 0;
        stim_done = 0;
        restart_hash();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, "abc", extremes, no-byte items
        row = mk(8'h00, 0, 1); row.use_known = 1; row.known_w0 = 32'he3b0c442;
        plan = {plan, row};
        plan = {plan, mk("a", 1, 0)};
        plan = {plan, mk("b", 1, 0)};
        row = mk("c", 1, 1); row.use_known = 1; row.known_w0 = 32'hba7816bf;
        plan = {plan, row};
        plan = {plan, mk(8'hff, 1, 0)};
        plan = {plan, mk(8'h5a, 0, 0)};
        plan = {plan, mk(8'h00, 1, 0)};
        plan = {plan, mk(8'hff, 0, 1)};
        plan = {plan, mk(8'h00, 1, 1)};
        plan = {plan, mk(8'hff, 1, 1)};
        plan = {plan, mk(8'ha5, 0, 0)};
        plan = {plan, mk(8'h00, 0, 1)};
        foreach (plan[i])
            send_request(plan[i]);

        // Random: messages of varied length, a few crossing block boundaries
        while (requests_sent < 370)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 5) n = $urandom_range(0, 20);
            else if (mode < 8) n = $urandom_range(50, 70);
            else n = $urandom_range(110, 130);
            if (n > 369 - requests_sent)
                n = 369 - requests_sent;
            for (int i = 0; i < n; i++)
                send_request(mk(8'($urandom), ($urandom_range(0, 7) != 0), 1'b0));
            send_request(mk(8'($urandom), 1'($urandom), 1'b1));
        end
        in_valid <= 1'b0;
        stim_done = 1;

        // Drain outstanding digest words
        while (digest_queue.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (known_first_word.size() > 0)
        begin
            $display("%0t: expected known digest words missing: %0d", $time,
                     known_first_word.size());
            error_count++;
        end
        $display("Sent %0d requests in %0d messages; checked %0d digest words.",
                 requests_sent, messages_sent, words_seen);
        if (error_count == 0)
            $display("sha256_stream_hasher_test: done, clean");
        else
            $display("sha256_stream_hasher_test: done, errors");
        $finish;
    end

endmodule
